// ----- design/cvs_pkg.sv -----
package cvs_pkg;

   // Field widths.
   localparam int VOLT_W = 16;
   localparam int MV_W   = 13;
   localparam int POS_W  = 8;
   localparam int PCT_W  = 7;
   localparam int FLAG_W = 4;

   // Limit flag bit positions.
   localparam int FLAG_OVER  = 0;
   localparam int FLAG_UNDER = 1;
   localparam int FLAG_HIGH  = 2;
   localparam int FLAG_LOW   = 3;

   // Configuration reset values, in units of 0.1 mV.
   localparam logic [VOLT_W-1:0] RESET_OVER_TRIP  = 16'd36500;
   localparam logic [VOLT_W-1:0] RESET_UNDER_TRIP = 16'd25000;
   localparam logic [VOLT_W-1:0] RESET_HIGH_WARN  = 16'd36000;
   localparam logic [VOLT_W-1:0] RESET_LOW_WARN   = 16'd28000;

   // Running minimum and maximum values at the start of a pass.
   localparam logic [VOLT_W-1:0] LOW_START  = 16'hFFFF;
   localparam logic [VOLT_W-1:0] HIGH_START = 16'h0000;

   // Divide by 10: multiply by ceil(2^19 / 10) and keep the upper bits.
   localparam int                DIV10_PROD_W = 32;
   localparam logic [VOLT_W-1:0] DIV10_MUL    = 16'd52429;
   localparam int                DIV10_SHIFT  = 19;

   // State of charge curve.
   localparam int LUT_POINTS  = 10;
   localparam int SEG_COUNT   = LUT_POINTS - 1;
   localparam int SEG_W       = 4;
   localparam int DIFF_W      = 12;
   localparam int SCALE_W     = 2;
   localparam int NUM_W       = 14;
   localparam int RECIP_W     = 20;
   localparam int RECIP_SHIFT = 24;
   localparam int PROD_W      = NUM_W + RECIP_W;
   localparam int QUOT_W      = 6;
   localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;

   localparam logic [VOLT_W-1:0] LUT_MV [LUT_POINTS] = '{
      16'd25000, 16'd28000, 16'd31000, 16'd32000, 16'd32500,
      16'd33000, 16'd33500, 16'd34500, 16'd36000, 16'd36500
   };
   localparam logic [PCT_W-1:0] LUT_PCT [LUT_POINTS] = '{
      7'd0, 7'd5, 7'd10, 7'd20, 7'd40, 7'd80, 7'd95, 7'd98, 7'd100, 7'd100
   };

   // Each segment slope dy/dx reduced to scale/divisor. The divisor is applied
   // as a multiply by ceil(2^24 / divisor), which is exact for the small
   // numerators that occur inside a segment.
   localparam logic [SCALE_W-1:0] SEG_SCALE [SEG_COUNT] = '{
      2'd1, 2'd1, 2'd1, 2'd1, 2'd2, 2'd3, 2'd3, 2'd1, 2'd0
   };
   localparam logic [RECIP_W-1:0] SEG_RECIP [SEG_COUNT] = '{
      20'd27963,   // divide by 600
      20'd27963,   // divide by 600
      20'd167773,  // divide by 100
      20'd671089,  // divide by 25
      20'd671089,  // divide by 25
      20'd167773,  // divide by 100
      20'd16778,   // divide by 1000
      20'd22370,   // divide by 750
      20'd0        // flat segment
   };

   // Configuration register indexes.
   typedef enum logic [1:0] {
      CSR_OVER_TRIP  = 2'd0,
      CSR_UNDER_TRIP = 2'd1,
      CSR_HIGH_WARN  = 2'd2,
      CSR_LOW_WARN   = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [VOLT_W-1:0] over_trip;
      logic [VOLT_W-1:0] under_trip;
      logic [VOLT_W-1:0] high_warn;
      logic [VOLT_W-1:0] low_warn;
   } limits_type;

   // Summary of one finished pass.
   typedef struct packed {
      logic [VOLT_W-1:0] low;
      logic [VOLT_W-1:0] high;
      logic [POS_W-1:0]  low_pos;
      logic [POS_W-1:0]  high_pos;
      logic [FLAG_W-1:0] flags;
   } pass_type;

   // One result transaction.
   typedef struct packed {
      logic [PCT_W-1:0]  charge_percent;
      logic [FLAG_W-1:0] flags;
      logic [POS_W-1:0]  highest_position;
      logic [POS_W-1:0]  lowest_position;
      logic [MV_W-1:0]   highest_mv;
      logic [MV_W-1:0]   lowest_mv;
   } result_type;

   function automatic logic [MV_W-1:0] div10(input logic [VOLT_W-1:0] v);
      logic [DIV10_PROD_W-1:0] p;
      p = DIV10_PROD_W'(v) * DIV10_PROD_W'(DIV10_MUL);
      return p[DIV10_SHIFT+MV_W-1:DIV10_SHIFT];
   endfunction

endpackage

// ----- design/cvs_accum.sv -----
module cvs_accum #(
   parameter logic [cvs_pkg::POS_W-1:0] SAT_LIMIT = 8'd255
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         take,
   input  logic [cvs_pkg::VOLT_W-1:0]   cell_voltage,
   input  logic                         last_cell,
   input  cvs_pkg::limits_type          limits,
   input  logic                         pass_ready,
   output logic                         pass_vld,
   output cvs_pkg::pass_type            pass
);

   logic [cvs_pkg::VOLT_W-1:0] low_ff, low_in, high_ff, high_in;
   logic [cvs_pkg::POS_W-1:0]  low_pos_ff, low_pos_in, high_pos_ff, high_pos_in;
   logic [cvs_pkg::POS_W-1:0]  count_ff, count_in;
   logic [cvs_pkg::FLAG_W-1:0] flags_ff, flags_in;
   logic                       pass_vld_ff, pass_vld_in;
   cvs_pkg::pass_type          pass_ff, pass_in;
   cvs_pkg::pass_type          upd;

   // Fold the incoming cell into the running pass values.
   always_comb begin
      upd.low      = low_ff;
      upd.low_pos  = low_pos_ff;
      upd.high     = high_ff;
      upd.high_pos = high_pos_ff;
      upd.flags    = flags_ff;
      if (cell_voltage < low_ff) begin
         upd.low     = cell_voltage;
         upd.low_pos = count_ff;
      end
      if (cell_voltage > high_ff) begin
         upd.high     = cell_voltage;
         upd.high_pos = count_ff;
      end
      if (cell_voltage > limits.over_trip)  upd.flags[cvs_pkg::FLAG_OVER]  = 1'b1;
      if (cell_voltage < limits.under_trip) upd.flags[cvs_pkg::FLAG_UNDER] = 1'b1;
      if (cell_voltage > limits.high_warn)  upd.flags[cvs_pkg::FLAG_HIGH]  = 1'b1;
      if (cell_voltage < limits.low_warn)   upd.flags[cvs_pkg::FLAG_LOW]   = 1'b1;
   end

   // Next pass state: update on each cell, start over after the last one.
   always_comb begin
      low_in      = low_ff;
      high_in     = high_ff;
      low_pos_in  = low_pos_ff;
      high_pos_in = high_pos_ff;
      count_in    = count_ff;
      flags_in    = flags_ff;
      if (take) begin
         if (last_cell) begin
            low_in      = cvs_pkg::LOW_START;
            high_in     = cvs_pkg::HIGH_START;
            low_pos_in  = '0;
            high_pos_in = '0;
            count_in    = '0;
            flags_in    = '0;
         end else begin
            low_in      = upd.low;
            high_in     = upd.high;
            low_pos_in  = upd.low_pos;
            high_pos_in = upd.high_pos;
            flags_in    = upd.flags;
            if (count_ff < SAT_LIMIT) count_in = count_ff + 1'b1;
         end
      end
   end

   // Pass summary register, loaded on the last cell.
   always_comb begin
      pass_in     = pass_ff;
      pass_vld_in = pass_vld_ff && !pass_ready;
      if (take && last_cell) begin
         pass_in     = upd;
         pass_vld_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff      <= cvs_pkg::LOW_START;
         high_ff     <= cvs_pkg::HIGH_START;
         low_pos_ff  <= '0;
         high_pos_ff <= '0;
         count_ff    <= '0;
         flags_ff    <= '0;
         pass_vld_ff <= 1'b0;
      end else begin
         low_ff      <= low_in;
         high_ff     <= high_in;
         low_pos_ff  <= low_pos_in;
         high_pos_ff <= high_pos_in;
         count_ff    <= count_in;
         flags_ff    <= flags_in;
         pass_vld_ff <= pass_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      pass_ff <= pass_in;
   end

   assign pass_vld = pass_vld_ff;
   assign pass     = pass_ff;

endmodule

// ----- design/cvs_soc.sv -----
module cvs_soc (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  pass_vld,
   input  cvs_pkg::pass_type     pass,
   output logic                  pass_ready,
   output logic                  out_vld,
   input  logic                  out_ready,
   output cvs_pkg::result_type   result
);

   // Stage one: segment search, offset and scaled numerator, divide by 10.
   logic                         q_vld_ff, q_vld_in;
   logic [cvs_pkg::MV_W-1:0]     q_low_mv_ff, q_high_mv_ff;
   logic [cvs_pkg::POS_W-1:0]    q_low_pos_ff, q_high_pos_ff;
   logic [cvs_pkg::FLAG_W-1:0]   q_flags_ff;
   logic [cvs_pkg::NUM_W-1:0]    q_num_ff, num;
   logic [cvs_pkg::SEG_W-1:0]    q_seg_ff, seg;
   logic                         q_below_ff, q_above_ff;
   logic [cvs_pkg::VOLT_W-1:0]   diff;
   logic [cvs_pkg::DIFF_W-1:0]   dv;

   // Stage two: reciprocal multiply, add the segment base and clamp.
   logic                         r_vld_ff, r_vld_in, r_ready;
   cvs_pkg::result_type          r_result_ff, r_result_in;
   logic [cvs_pkg::PROD_W-1:0]   prod;
   logic [cvs_pkg::QUOT_W-1:0]   quot;
   logic [cvs_pkg::PCT_W:0]      pct_sum;
   logic [cvs_pkg::PCT_W-1:0]    pct;

   assign r_ready    = !r_vld_ff || out_ready;
   assign pass_ready = !q_vld_ff || r_ready;
   assign q_vld_in   = pass_ready ? pass_vld : q_vld_ff;
   assign r_vld_in   = r_ready ? q_vld_ff : r_vld_ff;

   // Find the table segment holding the minimum voltage.
   always_comb begin
      seg = '0;
      for (int i = 1; i < cvs_pkg::SEG_COUNT; i++) begin
         if (pass.low >= cvs_pkg::LUT_MV[i]) seg = cvs_pkg::SEG_W'(i);
      end
      diff = pass.low - cvs_pkg::LUT_MV[seg];
      dv   = diff[cvs_pkg::DIFF_W-1:0];
      num  = cvs_pkg::NUM_W'(dv) * cvs_pkg::NUM_W'(cvs_pkg::SEG_SCALE[seg]);
   end

   always_ff @(posedge clock) begin
      if (pass_ready) begin
         q_low_mv_ff   <= cvs_pkg::div10(pass.low);
         q_high_mv_ff  <= cvs_pkg::div10(pass.high);
         q_low_pos_ff  <= pass.low_pos;
         q_high_pos_ff <= pass.high_pos;
         q_flags_ff    <= pass.flags;
         q_num_ff      <= num;
         q_seg_ff      <= seg;
         q_below_ff    <= pass.low <= cvs_pkg::LUT_MV[0];
         q_above_ff    <= pass.low >= cvs_pkg::LUT_MV[cvs_pkg::LUT_POINTS-1];
      end
   end

   // Interpolate within the segment.
   always_comb begin
      prod    = cvs_pkg::PROD_W'(q_num_ff) * cvs_pkg::PROD_W'(cvs_pkg::SEG_RECIP[q_seg_ff]);
      quot    = prod[cvs_pkg::RECIP_SHIFT+cvs_pkg::QUOT_W-1:cvs_pkg::RECIP_SHIFT];
      pct_sum = {1'b0, cvs_pkg::LUT_PCT[q_seg_ff]} + (cvs_pkg::PCT_W+1)'(quot);
      if (q_below_ff) begin
         pct = cvs_pkg::LUT_PCT[0];
      end else if (q_above_ff) begin
         pct = cvs_pkg::LUT_PCT[cvs_pkg::LUT_POINTS-1];
      end else if (pct_sum > (cvs_pkg::PCT_W+1)'(cvs_pkg::PCT_MAX)) begin
         pct = cvs_pkg::PCT_MAX;
      end else begin
         pct = pct_sum[cvs_pkg::PCT_W-1:0];
      end
      r_result_in.charge_percent   = pct;
      r_result_in.flags            = q_flags_ff;
      r_result_in.highest_position = q_high_pos_ff;
      r_result_in.lowest_position  = q_low_pos_ff;
      r_result_in.highest_mv       = q_high_mv_ff;
      r_result_in.lowest_mv        = q_low_mv_ff;
   end

   always_ff @(posedge clock) begin
      if (r_ready) begin
         r_result_ff <= r_result_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_vld_ff <= 1'b0;
         r_vld_ff <= 1'b0;
      end else begin
         q_vld_ff <= q_vld_in;
         r_vld_ff <= r_vld_in;
      end
   end

   assign out_vld = r_vld_ff;
   assign result  = r_result_ff;

endmodule

// ----- design/cell_voltage_supervisor_soc.sv -----
// The last cell's pass reaches rsp_tvalid through the pass summary register and result stages.
// Throughput: one cell per cycle; the accumulator and two result stages are fully pipelined.
// A stalled result port holds the result stages; cells keep flowing until they fill.
// Reset (synchronous, active high) restores the threshold reset values, clears the pass
// state and empties the result stages.
module cell_voltage_supervisor_soc #(
   parameter int MODULE_COUNT = 8,
   parameter int CELLS_EACH   = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // cell_voltage
   input  logic        req_tlast,   // last_cell
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // lowest_mv, highest_mv, lowest_position, highest_position, over_trip_seen,
   // under_trip_seen, high_warn_seen, low_warn_seen, charge_percent, zero fill
   output logic [55:0] rsp_tdata,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   localparam logic [cvs_pkg::POS_W-1:0] SAT_LIMIT =
      cvs_pkg::POS_W'(MODULE_COUNT * CELLS_EACH - 1);

   cvs_pkg::limits_type limits_ff, limits_in;
   cvs_pkg::pass_type   pass;
   cvs_pkg::result_type result;
   logic                pass_vld, soc_ready, take;

   // Threshold registers.
   always_comb begin
      limits_in = limits_ff;
      if (csr_write) begin
         case (cvs_pkg::csr_index_type'(csr_index))
            cvs_pkg::CSR_OVER_TRIP:  limits_in.over_trip  = csr_wdata;
            cvs_pkg::CSR_UNDER_TRIP: limits_in.under_trip = csr_wdata;
            cvs_pkg::CSR_HIGH_WARN:  limits_in.high_warn  = csr_wdata;
            cvs_pkg::CSR_LOW_WARN:   limits_in.low_warn   = csr_wdata;
            default:                 limits_in = limits_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limits_ff.over_trip  <= cvs_pkg::RESET_OVER_TRIP;
         limits_ff.under_trip <= cvs_pkg::RESET_UNDER_TRIP;
         limits_ff.high_warn  <= cvs_pkg::RESET_HIGH_WARN;
         limits_ff.low_warn   <= cvs_pkg::RESET_LOW_WARN;
      end else begin
         limits_ff <= limits_in;
      end
   end

   // Cell transactions are taken while the pass summary register can move on.
   assign req_tready = !pass_vld || soc_ready;
   assign take       = req_tvalid && req_tready;

   cvs_accum #(
      .SAT_LIMIT (SAT_LIMIT)
   ) u_accum (
      .clock        (clock),
      .reset        (reset),
      .take         (take),
      .cell_voltage (req_tdata),
      .last_cell    (req_tlast),
      .limits       (limits_ff),
      .pass_ready   (soc_ready),
      .pass_vld     (pass_vld),
      .pass         (pass)
   );

   cvs_soc u_soc (
      .clock      (clock),
      .reset      (reset),
      .pass_vld   (pass_vld),
      .pass       (pass),
      .pass_ready (soc_ready),
      .out_vld    (rsp_tvalid),
      .out_ready  (rsp_tready),
      .result     (result)
   );

   assign rsp_tdata = {3'b000, result};

   // The last cell of a pass always lands in the pass summary register.
   assert property (@(posedge clock) disable iff (reset)
      take && req_tlast |=> pass_vld)
      else $error("pass summary not loaded after last cell");

   // A waiting pass summary holds its contents.
   assert property (@(posedge clock) disable iff (reset)
      pass_vld && !soc_ready |=> pass_vld && $stable(pass))
      else $error("pass summary changed while stalled");

   // Minimum never exceeds maximum, and the charge stays within range.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (result.lowest_mv <= result.highest_mv) &&
                     (result.charge_percent <= cvs_pkg::PCT_MAX))
      else $error("inconsistent result");

endmodule
